[rtl/core/swmf_pkg.sv]
`default_nettype none

package swmf_pkg;

    // Widths of the stream fields.
    localparam int unsigned SAMPLE_FIELD_W = 16;
    localparam int unsigned FILL_FIELD_W   = 8;
    localparam int unsigned OUT_TDATA_W    = SAMPLE_FIELD_W + FILL_FIELD_W;

    // Flags that one cell hands to the next cell up the chain.
    typedef struct packed {
        logic seen;   // the evicted entry sits at or below this cell
        logic gt;     // the compacted entry here is above the new sample (or empty)
    } chain_t;

endpackage

`default_nettype wire

[rtl/core/swmf_cell.sv]
`default_nettype none

// One slot of the sorted window. Each request, the slot first closes the
// gap left by the evicted entry (taking its upper neighbor), then opens room
// for the new sample (taking its lower neighbor) or takes the sample itself.
module swmf_cell #(
    parameter int unsigned WINDOW      = 15,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         shift_en,
    input  wire                                         full,
    input  wire  signed [SAMPLE_BITS-1:0]               sample,
    // Compacted entry of the lower neighbor.
    input  wire  swmf_pkg::chain_t                      lo_link,
    input  wire  signed [SAMPLE_BITS-1:0]               lo_val,
    input  wire         [$clog2(WINDOW+1)-1:0]          lo_age,
    input  wire                                         lo_valid,
    // Stored entry of the upper neighbor.
    input  wire  signed [SAMPLE_BITS-1:0]               hi_val,
    input  wire         [$clog2(WINDOW+1)-1:0]          hi_age,
    input  wire                                         hi_valid,
    // To the upper neighbor.
    output swmf_pkg::chain_t                            up_link,
    output logic signed [SAMPLE_BITS-1:0]               up_val,
    output logic        [$clog2(WINDOW+1)-1:0]          up_age,
    // Stored entry, seen by both neighbors and the median select.
    output logic signed [SAMPLE_BITS-1:0]               val,
    output logic        [$clog2(WINDOW+1)-1:0]          age,
    output logic                                        valid
);

    localparam int unsigned AGE_W = $clog2(WINDOW + 1);

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic        [AGE_W-1:0]       age_reg, age_next;
    logic                          valid_reg, valid_next;

    logic                          evict;
    logic                          seen;
    logic signed [SAMPLE_BITS-1:0] c_val;
    logic        [AGE_W-1:0]       c_age;
    logic                          c_valid;
    logic                          c_gt;

    always_comb
    begin
        evict   = full && valid_reg && (age_reg == AGE_W'(WINDOW - 1));
        seen    = lo_link.seen || evict;
        c_val   = seen ? hi_val   : val_reg;
        c_age   = seen ? hi_age   : age_reg;
        c_valid = seen ? hi_valid : valid_reg;
        c_gt    = !c_valid || (c_val > sample);

        if (c_gt)
        begin
            if (!lo_link.gt)
            begin
                val_next = sample;
                age_next = '0;
            end
            else
            begin
                val_next = lo_val;
                age_next = lo_age + AGE_W'(1);
            end
        end
        else
        begin
            val_next = c_val;
            age_next = c_age + AGE_W'(1);
        end
        valid_next = valid_reg || lo_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    // Packed order of the link: seen above gt.
    assign up_link      = {seen, c_gt};
    assign up_val       = c_val;
    assign up_age       = c_age;
    assign val          = val_reg;
    assign age          = age_reg;
    assign valid        = valid_reg;

endmodule

`default_nettype wire

[rtl/core/sliding_window_median_filter_top.sv]
`default_nettype none

// Running median over the last WINDOW signed samples.
//
// Input channel (s_*): one request carries one sample in s_tdata[15:0],
// sign-extended from SAMPLE_BITS. Output channel (m_*): one request per input
// request carries the median in m_tdata[15:0] and the fill count in
// m_tdata[23:16]. For an even fill the upper of the two middle values is
// returned. Once WINDOW samples are held, the oldest one is dropped as each
// new one arrives, so the fill count stays at WINDOW.
//
// The window is a chain of WINDOW cells kept in ascending order. On an
// accepted request every cell updates in the same clock from its two
// neighbors, so a new sample can be taken every cycle while s_tready is
// high. The pick stage then selects the median from the updated chain and
// the output register holds it for the receiver. When the receiver stalls,
// one result waits in the output register and one more in the pick stage;
// s_tready then drops until the output register frees up. Reset empties the
// window and drops any result that has not been delivered.
module sliding_window_median_filter_top #(
    parameter int unsigned WINDOW      = 15,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [swmf_pkg::SAMPLE_FIELD_W-1:0]   s_tdata,   // [15:0] sample
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [swmf_pkg::OUT_TDATA_W-1:0]      m_tdata    // [15:0] median, [23:16] fill_count
);

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);

    logic signed [SAMPLE_BITS-1:0] sample;

    // Boundary entries sit at index WINDOW of the stored-entry arrays and at
    // index 0 of the compacted-entry arrays.
    logic signed [SAMPLE_BITS-1:0] cell_val   [WINDOW+1];
    logic        [CNT_W-1:0]       cell_age   [WINDOW+1];
    logic                          cell_valid [WINDOW+1];
    swmf_pkg::chain_t              c_link     [WINDOW+1];
    logic signed [SAMPLE_BITS-1:0] c_val      [WINDOW+1];
    logic        [CNT_W-1:0]       c_age      [WINDOW+1];
    logic                          lo_valid   [WINDOW+1];

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          full;
    logic                          accept;
    logic                          load_out;
    logic                          pick_valid_reg, pick_valid_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic signed [SAMPLE_BITS-1:0] med_sel;
    logic [swmf_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [swmf_pkg::SAMPLE_FIELD_W-1:0] med_field;

    // Take the sample at the configured width. A sample width above the
    // field width leaves the field value non-negative.
    generate
        if (SAMPLE_BITS <= swmf_pkg::SAMPLE_FIELD_W)
        begin : g_in_narrow
            assign sample = s_tdata[SAMPLE_BITS-1:0];
        end
        else
        begin : g_in_wide
            assign sample = {{(SAMPLE_BITS - swmf_pkg::SAMPLE_FIELD_W){1'b0}}, s_tdata};
        end
    endgenerate

    assign full     = (cnt_reg == CNT_W'(WINDOW));
    assign load_out = pick_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pick_valid_reg || load_out;
    assign accept   = s_tvalid && s_tready;

    // Chain ends: below the first cell is a valid slot that reads as
    // "not above the sample", above the last cell an empty slot.
    assign c_link[0]          = '0;
    assign c_val[0]           = '0;
    assign c_age[0]           = '0;
    assign lo_valid[0]        = 1'b1;
    assign cell_val[WINDOW]   = '0;
    assign cell_age[WINDOW]   = '0;
    assign cell_valid[WINDOW] = 1'b0;

    generate
        for (genvar i = 0; i < WINDOW; i++)
        begin : g_cell
            if (i > 0)
            begin : g_lo
                assign lo_valid[i] = cell_valid[i-1];
            end

            swmf_cell #(
                .WINDOW      (WINDOW),
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .full     (full),
                .sample   (sample),
                .lo_link  (c_link[i]),
                .lo_val   (c_val[i]),
                .lo_age   (c_age[i]),
                .lo_valid (lo_valid[i]),
                .hi_val   (cell_val[i+1]),
                .hi_age   (cell_age[i+1]),
                .hi_valid (cell_valid[i+1]),
                .up_link  (c_link[i+1]),
                .up_val   (c_val[i+1]),
                .up_age   (c_age[i+1]),
                .val      (cell_val[i]),
                .age      (cell_age[i]),
                .valid    (cell_valid[i])
            );
        end
    endgenerate

    // The pick stage reads the chain as left by the last accepted request;
    // the chain cannot move again before that pick is done.
    always_comb
    begin
        med_sel = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if ((cnt_reg >> 1) == CNT_W'(i))
            begin
                med_sel = cell_val[i];
            end
        end
    end

    generate
        if (SAMPLE_BITS >= swmf_pkg::SAMPLE_FIELD_W)
        begin : g_out_wide
            assign med_field = med_sel[swmf_pkg::SAMPLE_FIELD_W-1:0];
        end
        else
        begin : g_out_narrow
            assign med_field = {{(swmf_pkg::SAMPLE_FIELD_W - SAMPLE_BITS)
                                 {med_sel[SAMPLE_BITS-1]}}, med_sel};
        end
    endgenerate

    always_comb
    begin
        cnt_next        = cnt_reg;
        pick_valid_next = pick_valid_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (load_out)
        begin
            m_tvalid_next   = 1'b1;
            m_tdata_next    = {swmf_pkg::FILL_FIELD_W'(cnt_reg), med_field};
            pick_valid_next = 1'b0;
        end
        if (accept)
        begin
            pick_valid_next = 1'b1;
            if (!full)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            pick_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            pick_valid_reg <= pick_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A delivered fill count is never zero and never beyond the window.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[swmf_pkg::OUT_TDATA_W-1:swmf_pkg::SAMPLE_FIELD_W] != '0) &&
                     (m_tdata[swmf_pkg::OUT_TDATA_W-1:swmf_pkg::SAMPLE_FIELD_W] <=
                      swmf_pkg::FILL_FIELD_W'(WINDOW)))
        else $error("fill count out of range");

    // A window that holds samples always has its bottom cell filled.
    a_bottom_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> cell_valid[0])
        else $error("bottom cell empty while window holds samples");

    // A full window stays full.
    a_stay_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full) |=> (cnt_reg == CNT_W'(WINDOW)))
        else $error("fill count left the full window");

    // No new request while a pending pick cannot move on.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid_reg && m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("request taken while pick stage is blocked");

endmodule

`default_nettype wire
